// ----- rtl/core/adsr_pkg.sv -----
// Package for the linear ADSR envelope applier.
// Holds widths, register codes, sequencer states and the serial unit's
// request and response types. No dependencies.
package adsr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 24;
  localparam int LEVEL_BITS  = 16;
  localparam int FRAC_BITS   = 12;

  localparam int GAIN_BITS = 2 * LEVEL_BITS - FRAC_BITS;
  localparam int A_BITS = (LEVEL_BITS > SAMPLE_BITS) ? LEVEL_BITS : SAMPLE_BITS;
  localparam int B_BITS = (INDEX_BITS > GAIN_BITS) ? INDEX_BITS : GAIN_BITS;
  localparam int PROD_GAIN = LEVEL_BITS + INDEX_BITS + 1;
  localparam int PROD_SAMP = SAMPLE_BITS + GAIN_BITS;
  localparam int PROD_BITS = (PROD_GAIN > PROD_SAMP) ? PROD_GAIN : PROD_SAMP;
  localparam int REM_BITS  = INDEX_BITS + 1;
  localparam int CNT_BITS  = $clog2(A_BITS + 1);
  localparam int CFG_DATA_BITS = (INDEX_BITS > LEVEL_BITS) ? INDEX_BITS : LEVEL_BITS;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(64'd1 << FRAC_BITS);
  localparam logic [INDEX_BITS-1:0] INDEX_MAX   = {INDEX_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NOTE_LENGTH    = 3'd0,
    REG_ATTACK_LENGTH  = 3'd1,
    REG_DECAY_LENGTH   = 3'd2,
    REG_RELEASE_LENGTH = 3'd3,
    REG_ATTACK_LEVEL   = 3'd4,
    REG_SUSTAIN_LEVEL  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_GMUL,
    ST_GDIV,
    ST_RMUL,
    ST_RDIV,
    ST_XMUL,
    ST_SMUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    md_op_t                op;
    logic [A_BITS-1:0]     a1;
    logic [A_BITS-1:0]     a2;
    logic [B_BITS-1:0]     b1;
    logic [B_BITS-1:0]     b2;
    logic [INDEX_BITS-1:0] den;
  } md_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [PROD_BITS-1:0]  prod;
    logic [LEVEL_BITS-1:0] quo;
  } md_rsp_t;

  typedef struct packed {
    logic err;
    logic past;
    logic att;
    logic dec;
    logic rel;
    logic last;
  } flags_t;

endpackage

// ----- rtl/core/adsr_muldiv.sv -----
// Bit-serial multiply and divide unit of the ADSR envelope applier.
// Multiplies a sum of two products MSB first, or divides its last product.
// Depends on adsr_pkg.
module adsr_muldiv import adsr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_op_t                op_r, op_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [A_BITS-1:0]     ma1_r, ma1_nxt, ma2_r, ma2_nxt;
  logic [B_BITS-1:0]     b1_r, b1_nxt, b2_r, b2_nxt;
  logic [INDEX_BITS-1:0] den_r, den_nxt;
  logic [PROD_BITS-1:0]  acc_r, acc_nxt;
  logic [REM_BITS-1:0]   rem_r, rem_nxt;
  logic [LEVEL_BITS-1:0] quo_r, quo_nxt;

  logic [REM_BITS-1:0]   trial;
  logic                  fits;
  logic [PROD_BITS-1:0]  add1, add2;

  always_comb begin
    trial = {rem_r[INDEX_BITS-1:0], quo_r[LEVEL_BITS-1]};
    fits  = trial >= {1'b0, den_r};
    add1  = ma1_r[A_BITS-1] ? PROD_BITS'(b1_r) : '0;
    add2  = ma2_r[A_BITS-1] ? PROD_BITS'(b2_r) : '0;
  end

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    ma1_nxt  = ma1_r;
    ma2_nxt  = ma2_r;
    b1_nxt   = b1_r;
    b2_nxt   = b2_r;
    den_nxt  = den_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      if (req.op == MD_MUL) begin
        cnt_nxt = CNT_BITS'(A_BITS);
        ma1_nxt = req.a1;
        ma2_nxt = req.a2;
        b1_nxt  = req.b1;
        b2_nxt  = req.b2;
        acc_nxt = '0;
      end else begin
        cnt_nxt = CNT_BITS'(LEVEL_BITS);
        den_nxt = req.den;
        rem_nxt = acc_r[LEVEL_BITS +: REM_BITS];
        quo_nxt = acc_r[LEVEL_BITS-1:0];
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (op_r == MD_MUL) begin
        acc_nxt = {acc_r[PROD_BITS-2:0], 1'b0} + add1 + add2;
        ma1_nxt = {ma1_r[A_BITS-2:0], 1'b0};
        ma2_nxt = {ma2_r[A_BITS-2:0], 1'b0};
      end else begin
        rem_nxt = fits ? trial - {1'b0, den_r} : trial;
        quo_nxt = {quo_r[LEVEL_BITS-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= MD_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma1_r <= ma1_nxt;
    ma2_r <= ma2_nxt;
    b1_r  <= b1_nxt;
    b2_r  <= b2_nxt;
    den_r <= den_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- rtl/core/adsr_envelope_applier_unit.sv -----
// Top level of the linear ADSR envelope applier.
// Sequences gain, release and sample products through adsr_muldiv.
// Depends on adsr_pkg and adsr_muldiv.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_sample_in, in_note_start
//  out      output     out_valid / out_ready  out_sample_out, out_bounds_error, out_note_end
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Between acceptance and its result, a request runs a number of serial operations:
// 0 on a bounds error or past the note end, 1 in sustain, up to 6 when release
// overlaps attack or decay.
// Each operation retires one bit per cycle in the shared multiply/divide unit.
// Reset restores the register defaults and clears the sample index.
// A stalled result is held in the output register while the next request is taken.
module adsr_envelope_applier_unit import adsr_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  input  logic                            in_note_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   out_sample_out,
  output logic                            out_bounds_error,
  output logic                            out_note_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int Q_BITS = PROD_BITS - FRAC_BITS;
  localparam logic [Q_BITS-1:0] POS_LIMIT = Q_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [Q_BITS-1:0] NEG_LIMIT = Q_BITS'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic [PROD_BITS-1:0] ROUND_UP = PROD_BITS'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [INDEX_BITS-1:0] note_len_r, att_len_r, dec_len_r, rel_len_r;
  logic [LEVEL_BITS-1:0] att_lvl_r, sus_lvl_r;

  state_t                state_r, state_nxt;
  logic [INDEX_BITS-1:0] sample_index_r;
  logic [INDEX_BITS-1:0] i_r;
  logic [INDEX_BITS-1:0] i_start;
  logic [SAMPLE_BITS-1:0] s_r;
  logic [GAIN_BITS-1:0]  g_r, g_nxt;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_err_r, out_end_r;
  logic                   out_load;

  md_req_t md_req;
  md_rsp_t md_rsp;
  flags_t  fl;

  logic [REM_BITS-1:0]    sum_ad;
  logic [INDEX_BITS-1:0]  dec_hi, dec_lo, rel_b;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_BITS-1:0]   rounded;
  logic [Q_BITS-1:0]      q;
  logic [SAMPLE_BITS-1:0] y_mul, y_fin;

  adsr_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  function automatic md_req_t mul_req(input logic [A_BITS-1:0] a1,
                                      input logic [B_BITS-1:0] b1,
                                      input logic [A_BITS-1:0] a2,
                                      input logic [B_BITS-1:0] b2);
    md_req_t r;
    r       = '0;
    r.start = 1'b1;
    r.op    = MD_MUL;
    r.a1    = a1;
    r.b1    = b1;
    r.a2    = a2;
    r.b2    = b2;
    return r;
  endfunction

  function automatic md_req_t div_req(input logic [INDEX_BITS-1:0] den);
    md_req_t r;
    r       = '0;
    r.start = 1'b1;
    r.op    = MD_DIV;
    r.den   = den;
    return r;
  endfunction

  always_comb begin
    sum_ad   = {1'b0, att_len_r} + {1'b0, dec_len_r};
    fl.err   = (att_len_r > note_len_r) || (sum_ad > {1'b0, note_len_r}) ||
               (rel_len_r > note_len_r);
    fl.past  = i_r >= note_len_r;
    fl.att   = i_r < att_len_r;
    fl.dec   = !fl.att && ({1'b0, i_r} < sum_ad);
    fl.rel   = i_r >= (note_len_r - rel_len_r);
    fl.last  = (note_len_r != '0) && (i_r == note_len_r - 1'b1);
    dec_hi   = INDEX_BITS'(sum_ad - {1'b0, i_r});
    dec_lo   = i_r - att_len_r;
    rel_b    = note_len_r - 1'b1 - i_r;
    mag      = s_r[SAMPLE_BITS-1] ? (~s_r + 1'b1) : s_r;
    i_start  = in_note_start ? '0 : sample_index_r;
  end

  always_comb begin
    rounded = md_rsp.prod + (s_r[SAMPLE_BITS-1] ? ROUND_UP : '0);
    q       = rounded[PROD_BITS-1:FRAC_BITS];
    if (!s_r[SAMPLE_BITS-1]) begin
      y_mul = (q > POS_LIMIT) ? S_MAX : q[SAMPLE_BITS-1:0];
    end else begin
      y_mul = (q > NEG_LIMIT) ? S_MIN : (~q[SAMPLE_BITS-1:0] + 1'b1);
    end
    if (fl.err) begin
      y_fin = s_r;
    end else if (fl.past) begin
      y_fin = '0;
    end else begin
      y_fin = y_mul;
    end
  end

  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    md_req    = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (fl.err || fl.past) begin
          state_nxt = ST_OUT;
        end else if (fl.att) begin
          md_req    = mul_req(A_BITS'(att_lvl_r), B_BITS'(i_r), '0, '0);
          state_nxt = ST_GMUL;
        end else if (fl.dec) begin
          md_req    = mul_req(A_BITS'(att_lvl_r), B_BITS'(dec_hi),
                              A_BITS'(sus_lvl_r), B_BITS'(dec_lo));
          state_nxt = ST_GMUL;
        end else begin
          g_nxt = GAIN_BITS'(sus_lvl_r);
          if (fl.rel) begin
            md_req    = mul_req(A_BITS'(sus_lvl_r), B_BITS'(rel_b), '0, '0);
            state_nxt = ST_RMUL;
          end else begin
            md_req    = mul_req(A_BITS'(mag), B_BITS'(sus_lvl_r), '0, '0);
            state_nxt = ST_SMUL;
          end
        end
      end
      ST_GMUL: begin
        if (md_rsp.done) begin
          md_req    = div_req(fl.att ? att_len_r : dec_len_r);
          state_nxt = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (md_rsp.done) begin
          g_nxt = GAIN_BITS'(md_rsp.quo);
          if (fl.rel) begin
            md_req    = mul_req(A_BITS'(sus_lvl_r), B_BITS'(rel_b), '0, '0);
            state_nxt = ST_RMUL;
          end else begin
            md_req    = mul_req(A_BITS'(mag), B_BITS'(md_rsp.quo), '0, '0);
            state_nxt = ST_SMUL;
          end
        end
      end
      ST_RMUL: begin
        if (md_rsp.done) begin
          md_req    = div_req(rel_len_r);
          state_nxt = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (md_rsp.done) begin
          if (fl.att || fl.dec) begin
            md_req    = mul_req(A_BITS'(g_r[LEVEL_BITS-1:0]), B_BITS'(md_rsp.quo),
                                '0, '0);
            state_nxt = ST_XMUL;
          end else begin
            g_nxt     = GAIN_BITS'(md_rsp.quo);
            md_req    = mul_req(A_BITS'(mag), B_BITS'(md_rsp.quo), '0, '0);
            state_nxt = ST_SMUL;
          end
        end
      end
      ST_XMUL: begin
        if (md_rsp.done) begin
          g_nxt     = md_rsp.prod[FRAC_BITS +: GAIN_BITS];
          md_req    = mul_req(A_BITS'(mag), B_BITS'(md_rsp.prod[FRAC_BITS +: GAIN_BITS]),
                              '0, '0);
          state_nxt = ST_SMUL;
        end
      end
      ST_SMUL: begin
        if (md_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sample_index_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        sample_index_r <= (i_start == INDEX_MAX) ? i_start : i_start + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_r <= i_start;
      s_r <= in_sample_in;
    end
    g_r <= g_nxt;
    if (out_load) begin
      out_sample_r <= y_fin;
      out_err_r    <= fl.err;
      out_end_r    <= fl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_len_r <= '0;
      att_len_r  <= '0;
      dec_len_r  <= '0;
      rel_len_r  <= '0;
      att_lvl_r  <= LEVEL_RESET;
      sus_lvl_r  <= LEVEL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NOTE_LENGTH:    note_len_r <= cfg_data[INDEX_BITS-1:0];
        REG_ATTACK_LENGTH:  att_len_r  <= cfg_data[INDEX_BITS-1:0];
        REG_DECAY_LENGTH:   dec_len_r  <= cfg_data[INDEX_BITS-1:0];
        REG_RELEASE_LENGTH: rel_len_r  <= cfg_data[INDEX_BITS-1:0];
        REG_ATTACK_LEVEL:   att_lvl_r  <= cfg_data[LEVEL_BITS-1:0];
        REG_SUSTAIN_LEVEL:  sus_lvl_r  <= cfg_data[LEVEL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_bounds_error = out_err_r;
  assign out_note_end     = out_end_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> !md_rsp.busy)
    else $error("Serial unit started while busy.");

  a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> $stable(sample_index_r))
    else $error("Sample index moved without an accepted request.");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EVAL))
    else $error("Accepted request did not enter evaluation.");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("Result appeared outside the output state.");

endmodule
